// ----- rtl/sor_pkg.sv -----
package sor_pkg;

  localparam int unsigned MaxGridDefault  = 128;
  localparam int unsigned FracBitsDefault = 24;

  localparam int unsigned ValW   = 32;
  localparam int unsigned ErrW   = 31;
  localparam int unsigned SweepW = 16;

  localparam logic [1:0] ModeLoad   = 2'd0;
  localparam logic [1:0] ModeSolve  = 2'd1;
  localparam logic [1:0] ModeRead   = 2'd2;
  localparam logic [1:0] ModeUnused = 2'd3;

  localparam logic [2:0] RegGridSize    = 3'd0;
  localparam logic [2:0] RegRelaxFactor = 3'd1;
  localparam logic [2:0] RegTolerance   = 3'd2;
  localparam logic [2:0] RegCheckPeriod = 3'd3;
  localparam logic [2:0] RegMaxSweeps   = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [6:0]  row;
    logic [6:0]  col;
    logic [31:0] start_value;
    logic [31:0] reference_value;
  } sor_item_t;

  typedef struct packed {
    logic [31:0] cell_value;
    logic [15:0] sweeps_done;
    logic [30:0] final_error;
    logic        converged;
  } sor_result_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'sh7fffffff;
    if (v < -36'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// ----- rtl/sor_if.sv -----
interface sor_in_if import sor_pkg::*; ();
  logic      valid;
  logic      ready;
  sor_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sor_out_if import sor_pkg::*; ();
  logic        valid;
  logic        ready;
  sor_result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sor_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// ----- rtl/sor_laplace_grid_solver_top.sv -----
// SOR Laplace solver. Load items are written to the grid directly from idle; a read
// passes through S_READ to S_OUT; a solve walks the interior once per error check
// (S_ERR_RD, S_ERR_CMP per cell) and once per sweep (S_SW_C through S_SW_WR per cell),
// all through the single read port of the grid memory. A two-entry queue decouples input from work.
module sor_laplace_grid_solver_top import sor_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  sor_in_if.sink     in_if,
  sor_cfg_if.sink    cfg_if,
  sor_out_if.source  out_if
);
  sor_item_t q_data;
  logic q_valid, q_pop;
  logic [7:0]  grid_size_q, period_q;
  logic [23:0] relax_q;
  logic [24:0] tol_q;
  logic [15:0] max_q;

  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= 8'd22;
      relax_q <= 24'd6291456;
      tol_q <= 25'd16777;
      period_q <= 8'd20;
      max_q <= 16'hffff;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        RegGridSize:    grid_size_q <= cfg_if.wdata[7:0];
        RegRelaxFactor: relax_q <= cfg_if.wdata[23:0];
        RegTolerance:   tol_q <= cfg_if.wdata[24:0];
        RegCheckPeriod: period_q <= cfg_if.wdata[7:0];
        RegMaxSweeps:   max_q <= cfg_if.wdata[15:0];
        default: ;
      endcase
    end
  end

  sor_front u_front (
    .clk_i, .rst_ni, .in_if,
    .q_data_o(q_data), .q_valid_o(q_valid), .q_pop_i(q_pop)
  );

  sor_back u_back (
    .clk_i, .rst_ni,
    .q_data_i(q_data), .q_valid_i(q_valid), .q_pop_o(q_pop),
    .grid_size_i(grid_size_q), .relax_i(relax_q), .tol_i(tol_q),
    .period_i(period_q), .max_sweeps_i(max_q), .out_if
  );

  a_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.data.converged |-> out_if.data.cell_value == '0)
    else $error("converged result carries a cell value");
  a_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid)
    else $error("result dropped while stalled");
endmodule

// ----- rtl/sor_front.sv -----
module sor_front import sor_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sor_in_if.sink    in_if,
  output sor_item_t q_data_o,
  output logic      q_valid_o,
  input  logic      q_pop_i
);
  // two-entry queue of classified items; mode 3 is dropped here
  sor_item_t mem_q [2];
  logic      wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push;

  assign in_if.ready = (cnt_q != 2'd2);
  assign push = in_if.valid && in_if.ready && (in_if.data.mode != ModeUnused);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_if.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end
endmodule

// ----- rtl/sor_back.sv -----
module sor_back import sor_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sor_item_t   q_data_i,
  input  logic        q_valid_i,
  output logic        q_pop_o,
  input  logic [7:0]  grid_size_i,
  input  logic [23:0] relax_i,
  input  logic [24:0] tol_i,
  input  logic [7:0]  period_i,
  input  logic [15:0] max_sweeps_i,
  sor_out_if.source   out_if
);
  localparam int unsigned MaxGrid  = MaxGridDefault;
  localparam int unsigned FracBits = FracBitsDefault;
  localparam int unsigned IdxW  = $clog2(MaxGrid);
  localparam int unsigned AddrW = 2 * IdxW;
  localparam int unsigned Depth = MaxGrid * MaxGrid;

  typedef enum logic [3:0] {
    S_IDLE, S_ERR_RD, S_ERR_CMP, S_SW_C, S_SW_U, S_SW_D, S_SW_L, S_SW_R,
    S_SW_MUL, S_SW_WR, S_DECIDE, S_READ, S_OUT
  } state_e;

  logic [31:0] grid_mem [Depth];
  logic [31:0] ref_mem [Depth];

  state_e state_q;
  logic [IdxW-1:0] i_q, j_q, n_q;
  logic [AddrW-1:0] ra_q;
  logic [31:0] gd_q, rd_q;
  logic signed [31:0] c_q;
  logic signed [34:0] s_q;
  logic signed [59:0] p_q;
  logic [30:0] err_q, emax_q;
  logic [15:0] done_q;
  logic [7:0]  pcnt_q;
  logic        rd_pend_q;
  sor_result_t res_q;
  logic        out_v_q;

  logic [IdxW:0] n_full;
  logic        in_grid;
  logic [AddrW-1:0] ld_addr;
  logic [AddrW-1:0] cur_addr;
  logic signed [32:0] diff;
  logic [32:0] adiff;
  logic [30:0] adsat;
  logic signed [59:0] fl;
  logic signed [35:0] nv;
  logic [7:0] period;
  logic last_j, last_i;
  logic pop_done;

  always_comb begin
    if (grid_size_i < 8'd3) n_full = (IdxW+1)'(3);
    else if (32'(grid_size_i) > MaxGrid) n_full = (IdxW+1)'(MaxGrid);
    else n_full = (IdxW+1)'(grid_size_i);
  end

  assign in_grid = (32'(q_data_i.row) < MaxGrid) && (32'(q_data_i.col) < MaxGrid);
  assign ld_addr = {q_data_i.row[IdxW-1:0], q_data_i.col[IdxW-1:0]};
  assign cur_addr = {i_q, j_q};
  assign period = (period_i == 8'd0) ? 8'd1 : period_i;
  assign last_j = (j_q == n_q - IdxW'(2));
  assign last_i = (i_q == n_q - IdxW'(2));

  assign diff = $signed({rd_q[31], rd_q}) - $signed({gd_q[31], gd_q});
  assign adiff = diff[32] ? 33'(-diff) : 33'(diff);
  assign adsat = (adiff > 33'h7fffffff) ? 31'h7fffffff : adiff[30:0];
  assign fl = p_q >>> FracBits;
  assign nv = 36'(c_q) + 36'(fl);

  // pop loads at once, solves and reads when their result is issued
  assign pop_done = (state_q == S_OUT) && (!out_v_q || out_if.ready);
  assign q_pop_o = (q_valid_i && (state_q == S_IDLE) && (q_data_i.mode == ModeLoad))
                   || pop_done;
  assign out_if.valid = out_v_q;
  assign out_if.data = res_q;

  // memory ports: one read address, one write address per cycle
  always_ff @(posedge clk_i) begin
    gd_q <= grid_mem[ra_q];
    rd_q <= ref_mem[ra_q];
    if (q_valid_i && (state_q == S_IDLE) && (q_data_i.mode == ModeLoad) && in_grid) begin
      grid_mem[ld_addr] <= q_data_i.start_value;
      ref_mem[ld_addr] <= q_data_i.reference_value;
    end else if (state_q == S_SW_WR) begin
      grid_mem[cur_addr] <= sat32(nv);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
      rd_pend_q <= 1'b0;
      i_q <= '0; j_q <= '0; n_q <= '0; ra_q <= '0;
      c_q <= '0; s_q <= '0; p_q <= '0;
      err_q <= '0; emax_q <= '0; done_q <= '0; pcnt_q <= '0;
      res_q <= '0;
    end else begin
      if (pop_done) out_v_q <= 1'b1;
      else if (out_if.valid && out_if.ready) out_v_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (q_valid_i && q_data_i.mode == ModeSolve) begin
            // n of MaxGrid wraps to zero; last_i and last_j still land on n-2
            n_q <= n_full[IdxW-1:0];
            i_q <= IdxW'(1); j_q <= IdxW'(1);
            ra_q <= {IdxW'(1), IdxW'(1)};
            emax_q <= '0; done_q <= '0; pcnt_q <= '0;
            state_q <= S_ERR_RD;
          end else if (q_valid_i && q_data_i.mode == ModeRead) begin
            ra_q <= ld_addr;
            rd_pend_q <= in_grid;
            state_q <= S_READ;
          end
        end
        S_READ: state_q <= S_OUT;
        S_ERR_RD: state_q <= S_ERR_CMP;
        S_ERR_CMP: begin
          if (adsat > emax_q) emax_q <= adsat;
          if (last_j) begin
            j_q <= IdxW'(1);
            if (last_i) begin
              err_q <= (adsat > emax_q) ? adsat : emax_q;
              i_q <= IdxW'(1);
              state_q <= S_DECIDE;
            end else begin
              i_q <= i_q + IdxW'(1);
              ra_q <= {i_q + IdxW'(1), IdxW'(1)};
              state_q <= S_ERR_RD;
            end
          end else begin
            j_q <= j_q + IdxW'(1);
            ra_q <= {i_q, j_q + IdxW'(1)};
            state_q <= S_ERR_RD;
          end
        end
        S_DECIDE: begin
          if (err_q >= {6'd0, tol_i} && done_q < max_sweeps_i) begin
            ra_q <= cur_addr;
            state_q <= S_SW_C;
          end else begin
            state_q <= S_OUT;
          end
        end
        // sweep: fetch centre, up, down, left, right one per cycle
        S_SW_C: begin
          ra_q <= {i_q - IdxW'(1), j_q};
          state_q <= S_SW_U;
        end
        S_SW_U: begin
          c_q <= gd_q;
          s_q <= -35'sd4 * 35'($signed(gd_q));
          ra_q <= {i_q + IdxW'(1), j_q};
          state_q <= S_SW_D;
        end
        S_SW_D: begin
          s_q <= s_q + 35'($signed(gd_q));
          ra_q <= {i_q, j_q - IdxW'(1)};
          state_q <= S_SW_L;
        end
        S_SW_L: begin
          s_q <= s_q + 35'($signed(gd_q));
          ra_q <= {i_q, j_q + IdxW'(1)};
          state_q <= S_SW_R;
        end
        S_SW_R: begin
          s_q <= s_q + 35'($signed(gd_q));
          state_q <= S_SW_MUL;
        end
        S_SW_MUL: begin
          p_q <= 60'($signed({1'b0, relax_i}) * (s_q + 35'($signed(gd_q))));
          state_q <= S_SW_WR;
        end
        S_SW_WR: begin
          if (last_j) begin
            j_q <= IdxW'(1);
            if (last_i) begin
              i_q <= IdxW'(1);
              done_q <= done_q + 16'd1;
              ra_q <= {IdxW'(1), IdxW'(1)};
              if (pcnt_q + 8'd1 == period) begin
                pcnt_q <= '0;
                emax_q <= '0;
                state_q <= S_ERR_RD;
              end else begin
                pcnt_q <= pcnt_q + 8'd1;
                state_q <= S_DECIDE;
              end
            end else begin
              i_q <= i_q + IdxW'(1);
              ra_q <= {i_q + IdxW'(1), IdxW'(1)};
              state_q <= S_SW_C;
            end
          end else begin
            j_q <= j_q + IdxW'(1);
            ra_q <= {i_q, j_q + IdxW'(1)};
            state_q <= S_SW_C;
          end
        end
        S_OUT: begin
          // load the result word only once the previous one has left or is leaving
          if (pop_done) begin
            if (q_data_i.mode == ModeRead)
              res_q <= '{cell_value: rd_pend_q ? gd_q : '0, sweeps_done: '0,
                         final_error: '0, converged: 1'b0};
            else
              res_q <= '{cell_value: '0, sweeps_done: done_q, final_error: err_q,
                         converged: (err_q < {6'd0, tol_i})};
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
